FILE: hdl/hcbd_pkg.sv
package hcbd_pkg;

	localparam logic [7:0] LF_CHAR = 8'h0A;
	localparam int unsigned OUT_TOTAL_BITS = 32;

	typedef enum logic [3:0] {
		PH_SIZE  = 4'b0001,
		PH_DATA  = 4'b0010,
		PH_TRAIL = 4'b0100,
		PH_DONE  = 4'b1000
	} phase_t;

	typedef enum logic [1:0] {
		ERR_OK       = 2'd0,
		ERR_NODIGITS = 2'd1,
		ERR_OVERFLOW = 2'd2,
		ERR_TRUNC    = 2'd3
	} err_t;

	typedef struct packed {
		logic [7:0] byte_value;
		logic       first_of_buffer;
		logic       last_of_buffer;
	} in_item_t;

	typedef struct packed {
		logic [7:0]                data_byte;
		logic                      data_valid;
		logic                      finished;
		logic [OUT_TOTAL_BITS-1:0] total_length;
		err_t                      error_code;
	} out_item_t;

endpackage

FILE: hdl/hcbd_in_if.sv
interface hcbd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_value;
	logic       first_of_buffer;
	logic       last_of_buffer;

	modport source (output valid, byte_value, first_of_buffer, last_of_buffer, input ready);
	modport sink (input valid, byte_value, first_of_buffer, last_of_buffer, output ready);
endinterface

FILE: hdl/hcbd_out_if.sv
interface hcbd_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  data_byte;
	logic        data_valid;
	logic        finished;
	logic [31:0] total_length;
	logic [1:0]  error_code;

	modport source (output valid, data_byte, data_valid, finished, total_length, error_code,
		input ready);
	modport sink (input valid, data_byte, data_valid, finished, total_length, error_code,
		output ready);
endinterface

FILE: hdl/hcbd_core.sv
module hcbd_core #(
	parameter int unsigned SIZE_BITS  = 24,
	parameter int unsigned TOTAL_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  hcbd_pkg::in_item_t  item,
	output logic                emit,
	output hcbd_pkg::out_item_t res
);

	hcbd_pkg::phase_t        phase_q, phase_e, phase_n;
	logic [SIZE_BITS-1:0]    chunk_q, chunk_e, chunk_n;
	logic [SIZE_BITS-1:0]    left_q, left_e, left_n, left_dec;
	logic [TOTAL_BITS-1:0]   total_q, total_e, total_n;
	logic                    seen_q, seen_e, seen_n;
	logic                    closed_q, closed_e, closed_n;
	logic                    valid, fin;
	hcbd_pkg::err_t          err;
	logic [3:0]              hex_val;
	logic                    hex_ok;
	logic [TOTAL_BITS+31:0]  total_wide;
	logic [7:0]              b;

	assign b = item.byte_value;

	always_comb begin
		hex_ok  = 1'b1;
		hex_val = 4'd0;
		if (b >= 8'h30 && b <= 8'h39) begin
			hex_val = 4'(b - 8'h30);
		end else if (b >= 8'h61 && b <= 8'h66) begin
			hex_val = 4'(b - 8'h57);
		end else if (b >= 8'h41 && b <= 8'h46) begin
			hex_val = 4'(b - 8'h37);
		end else begin
			hex_ok = 1'b0;
		end
	end

	// A new body starts from the reset state before its first byte is decoded.
	always_comb begin
		if (item.first_of_buffer) begin
			phase_e  = hcbd_pkg::PH_SIZE;
			chunk_e  = '0;
			left_e   = '0;
			total_e  = '0;
			seen_e   = 1'b0;
			closed_e = 1'b0;
		end else begin
			phase_e  = phase_q;
			chunk_e  = chunk_q;
			left_e   = left_q;
			total_e  = total_q;
			seen_e   = seen_q;
			closed_e = closed_q;
		end
	end

	assign left_dec = (left_e != '0) ? left_e - 1'b1 : left_e;

	always_comb begin
		phase_n  = phase_e;
		chunk_n  = chunk_e;
		left_n   = left_e;
		total_n  = total_e;
		seen_n   = seen_e;
		closed_n = closed_e;
		valid    = 1'b0;
		fin      = 1'b0;
		err      = hcbd_pkg::ERR_OK;
		unique case (phase_e)
			hcbd_pkg::PH_SIZE: begin
				if (b == hcbd_pkg::LF_CHAR) begin
					if (!seen_e) begin
						fin = 1'b1;
						err = hcbd_pkg::ERR_NODIGITS;
					end else if (chunk_e == '0) begin
						fin = 1'b1;
					end else begin
						left_n  = chunk_e;
						phase_n = hcbd_pkg::PH_DATA;
					end
				end else if (hex_ok && !closed_e) begin
					if (chunk_e[SIZE_BITS-1 -: 4] != 4'd0) begin
						fin = 1'b1;
						err = hcbd_pkg::ERR_OVERFLOW;
					end else begin
						chunk_n = {chunk_e[SIZE_BITS-5:0], hex_val};
						seen_n  = 1'b1;
					end
				end else begin
					closed_n = 1'b1;
				end
			end
			hcbd_pkg::PH_DATA: begin
				valid  = 1'b1;
				left_n = left_dec;
				if (total_e != '1) begin
					total_n = total_e + 1'b1;
				end
				if (left_dec == '0) begin
					phase_n = hcbd_pkg::PH_TRAIL;
				end
			end
			hcbd_pkg::PH_TRAIL: begin
				if (b == hcbd_pkg::LF_CHAR) begin
					chunk_n  = '0;
					seen_n   = 1'b0;
					closed_n = 1'b0;
					phase_n  = hcbd_pkg::PH_SIZE;
				end
			end
			default: begin
			end
		endcase
		// Once finished, bytes are dropped until the next body starts.
		if (phase_e != hcbd_pkg::PH_DONE) begin
			if (!fin && item.last_of_buffer) begin
				fin = 1'b1;
				err = hcbd_pkg::ERR_TRUNC;
			end
			if (fin) begin
				phase_n = hcbd_pkg::PH_DONE;
			end
		end
	end

	assign total_wide = {32'd0, total_n};
	assign emit       = valid || fin;

	always_comb begin
		res.data_byte    = valid ? b : 8'd0;
		res.data_valid   = valid;
		res.finished     = fin;
		res.total_length = (|total_wide[TOTAL_BITS+31:32]) ? '1 : total_wide[31:0];
		res.error_code   = fin ? err : hcbd_pkg::ERR_OK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= hcbd_pkg::PH_SIZE;
			chunk_q  <= '0;
			left_q   <= '0;
			total_q  <= '0;
			seen_q   <= 1'b0;
			closed_q <= 1'b0;
		end else if (step) begin
			phase_q  <= phase_n;
			chunk_q  <= chunk_n;
			left_q   <= left_n;
			total_q  <= total_n;
			seen_q   <= seen_n;
			closed_q <= closed_n;
		end
	end

endmodule

FILE: hdl/hcbd_out_stage.sv
module hcbd_out_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  hcbd_pkg::out_item_t din,
	output logic                slot_free,
	hcbd_out_if.source          result
);

	logic                valid_q;
	hcbd_pkg::out_item_t data_q;

	assign slot_free = !valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (slot_free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (slot_free && load) begin
			data_q <= din;
		end
	end

	assign result.valid        = valid_q;
	assign result.data_byte    = data_q.data_byte;
	assign result.data_valid   = data_q.data_valid;
	assign result.finished     = data_q.finished;
	assign result.total_length = data_q.total_length;
	assign result.error_code   = data_q.error_code;

endmodule

FILE: hdl/http_chunked_body_decoder.sv
// Channel  Role  Beat payload
// body     sink  byte_value, first_of_buffer, last_of_buffer
// result   src   data_byte, data_valid, finished, total_length, error_code
//
// One body byte per cycle unless a result beat stalls: a byte enters the input register,
// is decoded against the state registers in the next cycle and its result, if any,
// lands in the output register.
// Reset clears the decoder state and both stage valid flags; no beat is pending after it.
// A stalled result beat holds the output register; the input register keeps draining
// bytes that give no result, and body.ready drops only when a result cannot move on.
module http_chunked_body_decoder #(
	parameter int unsigned SIZE_BITS  = 24,
	parameter int unsigned TOTAL_BITS = 32
) (
	input logic         clk,
	input logic         arst_n,
	hcbd_in_if.sink     body,
	hcbd_out_if.source  result
);

	logic                valid_s1;
	hcbd_pkg::in_item_t  item_s1;
	logic                drain;
	logic                emit;
	logic                slot_free;
	hcbd_pkg::out_item_t res;

	assign drain      = valid_s1 && (!emit || slot_free);
	assign body.ready = !valid_s1 || drain;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (body.ready) begin
			valid_s1 <= body.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (body.ready && body.valid) begin
			item_s1.byte_value      <= body.byte_value;
			item_s1.first_of_buffer <= body.first_of_buffer;
			item_s1.last_of_buffer  <= body.last_of_buffer;
		end
	end

	hcbd_core #(
		.SIZE_BITS  (SIZE_BITS),
		.TOTAL_BITS (TOTAL_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (drain),
		.item   (item_s1),
		.emit   (emit),
		.res    (res)
	);

	hcbd_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (drain && emit),
		.din       (res),
		.slot_free (slot_free),
		.result    (result)
	);

endmodule

FILE: dv/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned SIZE_BITS  = 24;
	localparam int unsigned TOTAL_BITS = 32;
	localparam logic [7:0] CR_CHAR     = 8'h0D;
	localparam int         RANDOM_ITEMS = 1050;
	localparam int         CYCLE_LIMIT  = 200000;

	logic clk;
	logic arst_n;

	hcbd_in_if  bif ();
	hcbd_out_if rif ();

	http_chunked_body_decoder #(
		.SIZE_BITS (SIZE_BITS),
		.TOTAL_BITS(TOTAL_BITS)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.body  (bif),
		.result(rif)
	);

	// Decoder state as the testbench tracks it.
	hcbd_pkg::phase_t      dec_phase         = hcbd_pkg::PH_SIZE;
	logic [SIZE_BITS-1:0]  dec_size          = '0;
	logic [SIZE_BITS-1:0]  dec_left          = '0;
	logic [TOTAL_BITS-1:0] dec_total         = '0;
	bit                    dec_digit_seen    = 1'b0;
	bit                    dec_digits_closed = 1'b0;

	hcbd_pkg::in_item_t    pending_bytes[$];
	hcbd_pkg::out_item_t   decoded_q[$];
	logic [7:0]            body_bytes[$];

	hcbd_pkg::in_item_t    next_byte;
	hcbd_pkg::out_item_t   decoded;
	hcbd_pkg::out_item_t   expected_beat;
	hcbd_pkg::out_item_t   seen_beat;
	bit          in_taken    = 1'b0;
	bit          out_taken   = 1'b0;
	bit          steady_in   = 1'b0;
	bit          steady_out  = 1'b0;
	int          gap_left;
	int          stall_left;
	int          errors      = 0;
	int          cycle_count = 0;

	function automatic int hex_nibble(input logic [7:0] c);
		if (c >= "0" && c <= "9") return int'(c - "0");
		if (c >= "a" && c <= "f") return int'(c - "a") + 10;
		if (c >= "A" && c <= "F") return int'(c - "A") + 10;
		return -1;
	endfunction

	function automatic logic [7:0] hex_char(input int unsigned v, input bit upper);
		if (v < 10) return 8'("0" + v);
		return upper ? 8'("A" + v - 10) : 8'("a" + v - 10);
	endfunction

	function automatic void clear_size_line();
		dec_size          = '0;
		dec_digit_seen    = 1'b0;
		dec_digits_closed = 1'b0;
	endfunction

	function automatic void clear_decoder();
		dec_phase = hcbd_pkg::PH_SIZE;
		dec_left  = '0;
		dec_total = '0;
		clear_size_line();
	endfunction

	// Returns 1 when the byte yields a result beat, and that beat in res.
	function automatic bit decode_body_byte(input hcbd_pkg::in_item_t it,
			output hcbd_pkg::out_item_t res);
		int             nib;
		bit             payload;
		bit             fin;
		hcbd_pkg::err_t code;
		payload = 1'b0;
		fin     = 1'b0;
		code    = hcbd_pkg::ERR_OK;
		res     = '0;
		if (it.first_of_buffer)
			clear_decoder();
		nib = hex_nibble(it.byte_value);
		case (dec_phase)
			hcbd_pkg::PH_SIZE: begin
				if (it.byte_value == hcbd_pkg::LF_CHAR) begin
					if (!dec_digit_seen) begin
						fin  = 1'b1;
						code = hcbd_pkg::ERR_NODIGITS;
					end else if (dec_size == '0) begin
						fin = 1'b1;
					end else begin
						dec_left  = dec_size;
						dec_phase = hcbd_pkg::PH_DATA;
					end
				end else if (nib >= 0 && !dec_digits_closed) begin
					if (dec_size[SIZE_BITS-1 -: 4] != '0) begin
						fin  = 1'b1;
						code = hcbd_pkg::ERR_OVERFLOW;
					end else begin
						dec_size       = {dec_size[SIZE_BITS-5:0], 4'(nib)};
						dec_digit_seen = 1'b1;
					end
				end else begin
					dec_digits_closed = 1'b1;
				end
			end
			hcbd_pkg::PH_DATA: begin
				payload = 1'b1;
				if (dec_total != '1)
					dec_total++;
				if (dec_left != '0)
					dec_left--;
				if (dec_left == '0)
					dec_phase = hcbd_pkg::PH_TRAIL;
			end
			hcbd_pkg::PH_TRAIL: begin
				if (it.byte_value == hcbd_pkg::LF_CHAR) begin
					clear_size_line();
					dec_phase = hcbd_pkg::PH_SIZE;
				end
			end
			default: return 1'b0;
		endcase
		if (!fin && it.last_of_buffer) begin
			fin  = 1'b1;
			code = hcbd_pkg::ERR_TRUNC;
		end
		if (fin)
			dec_phase = hcbd_pkg::PH_DONE;
		if (!payload && !fin)
			return 1'b0;
		res.data_byte    = payload ? it.byte_value : 8'h00;
		res.data_valid   = payload;
		res.finished     = fin;
		res.total_length = dec_total;
		res.error_code   = fin ? code : hcbd_pkg::ERR_OK;
		return 1'b1;
	endfunction

	function automatic void put(input logic [7:0] b);
		body_bytes.push_back(b);
	endfunction

	function automatic logic [7:0] any_but_lf();
		logic [7:0] b;
		b = 8'($urandom_range(0, 255));
		return (b == hcbd_pkg::LF_CHAR) ? CR_CHAR : b;
	endfunction

	// Size line with optional leading zeros, mixed-case digits and an extension.
	function automatic void put_size_line(input int unsigned v);
		int n;
		n = 1;
		while (n < 8 && (v >> (4 * n)) != 0)
			n++;
		if ($urandom_range(0, 4) == 0)
			repeat ($urandom_range(1, 2)) put("0");
		for (int i = n - 1; i >= 0; i--)
			put(hex_char((v >> (4 * i)) & 15, 1'($urandom_range(0, 1))));
		if ($urandom_range(0, 3) == 0) begin
			put(";");
			repeat ($urandom_range(0, 4)) put(any_but_lf());
		end
		if ($urandom_range(0, 5) != 0)
			put(CR_CHAR);
		put(hcbd_pkg::LF_CHAR);
	endfunction

	function automatic void put_trailer();
		if ($urandom_range(0, 4) != 0) begin
			put(CR_CHAR);
		end else begin
			repeat ($urandom_range(0, 3)) put(any_but_lf());
		end
		put(hcbd_pkg::LF_CHAR);
	endfunction

	// Moves the assembled body into the send queue. A cut index ends the body early
	// with last_of_buffer on that byte.
	function automatic int emit_body(input int cut, input bit last_at_end);
		int n;
		hcbd_pkg::in_item_t it;
		n = (cut >= 0) ? cut + 1 : body_bytes.size();
		for (int i = 0; i < n; i++) begin
			it.byte_value      = body_bytes[i];
			it.first_of_buffer = (i == 0);
			it.last_of_buffer  = (i == cut) || (last_at_end && i == n - 1);
			pending_bytes.push_back(it);
		end
		body_bytes.delete();
		return n;
	endfunction

	task automatic build_random_body(output int counted);
		int kind;
		int core;
		int cut;
		int n;
		int sz;
		bit last_at_end;
		kind        = $urandom_range(0, 9);
		cut         = -1;
		last_at_end = 1'b0;
		case (kind)
			7: begin
				// Widest legal size, then cut short after a few payload bytes.
				put_size_line(($urandom_range(1, 15) << 20) | $urandom_range(0, 20'hFFFFF));
				repeat ($urandom_range(1, 6)) put(8'($urandom_range(0, 255)));
				cut = body_bytes.size() - 1;
			end
			8: begin
				put(hex_char($urandom_range(1, 15), 1'($urandom_range(0, 1))));
				repeat ($urandom_range(6, 8))
					put(hex_char($urandom_range(0, 15), 1'($urandom_range(0, 1))));
				put(hcbd_pkg::LF_CHAR);
				last_at_end = 1'($urandom_range(0, 1));
			end
			9: begin
				repeat ($urandom_range(1, 12)) begin
					case ($urandom_range(0, 3))
						0: put(hex_char($urandom_range(0, 15), 1'($urandom_range(0, 1))));
						1: put(hcbd_pkg::LF_CHAR);
						2: put(CR_CHAR);
						default: put(8'($urandom_range(0, 255)));
					endcase
				end
				last_at_end = 1'($urandom_range(0, 1));
			end
			default: begin
				repeat ($urandom_range(0, 3)) begin
					sz = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 60)
						: $urandom_range(1, 8);
					put_size_line(sz);
					repeat (sz) put(8'($urandom_range(0, 255)));
					put_trailer();
				end
				put_size_line(0);
				if ($urandom_range(0, 4) == 0)
					cut = $urandom_range(0, body_bytes.size() - 1);
				last_at_end = ($urandom_range(0, 2) == 0);
			end
		endcase
		core = body_bytes.size();
		// Bytes after the end of a body are ignored and are not counted.
		if (cut < 0 && $urandom_range(0, 5) == 0)
			repeat ($urandom_range(1, 3)) put(8'($urandom_range(0, 255)));
		n = emit_body(cut, last_at_end);
		counted = (n < core) ? n : core;
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	// Input side: record accepted beats and predict their results.
	always @(posedge clk) begin
		in_taken <= bif.valid && bif.ready;
		if (arst_n && bif.valid && bif.ready) begin
			if (decode_body_byte('{bif.byte_value, bif.first_of_buffer, bif.last_of_buffer},
					decoded))
				decoded_q.push_back(decoded);
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			bif.valid <= 1'b0;
			gap_left = 0;
		end else if (!bif.valid || in_taken) begin
			if (gap_left > 0) begin
				bif.valid <= 1'b0;
				gap_left--;
			end else if (pending_bytes.size() != 0) begin
				next_byte = pending_bytes.pop_front();
				bif.valid           <= 1'b1;
				bif.byte_value      <= next_byte.byte_value;
				bif.first_of_buffer <= next_byte.first_of_buffer;
				bif.last_of_buffer  <= next_byte.last_of_buffer;
				if ($urandom_range(0, 49) == 0)
					steady_in = !steady_in;
				gap_left = steady_in ? 0 : $urandom_range(0, 5);
			end else begin
				bif.valid <= 1'b0;
			end
		end
	end

	// Output side: compare each result beat with the oldest prediction.
	always @(posedge clk) begin
		out_taken <= rif.valid && rif.ready;
		if (arst_n && rif.valid && rif.ready) begin
			seen_beat = '{rif.data_byte, rif.data_valid, rif.finished, rif.total_length,
				hcbd_pkg::err_t'(rif.error_code)};
			if (decoded_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result beat byte=%02h dv=%0b fin=%0b total=%0d err=%0d",
					$time, seen_beat.data_byte, seen_beat.data_valid, seen_beat.finished,
					seen_beat.total_length, seen_beat.error_code);
			end else begin
				expected_beat = decoded_q.pop_front();
				if (seen_beat !== expected_beat) begin
					errors++;
					$display("%0t: mismatch expected byte=%02h dv=%0b fin=%0b total=%0d err=%0d",
						$time, expected_beat.data_byte, expected_beat.data_valid,
						expected_beat.finished, expected_beat.total_length,
						expected_beat.error_code);
					$display("%0t:          actual byte=%02h dv=%0b fin=%0b total=%0d err=%0d",
						$time, seen_beat.data_byte, seen_beat.data_valid, seen_beat.finished,
						seen_beat.total_length, seen_beat.error_code);
				end
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			rif.ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_taken) begin
				if ($urandom_range(0, 49) == 0)
					steady_out = !steady_out;
				stall_left = steady_out ? 0 : $urandom_range(0, 5);
			end
			if (stall_left > 0) begin
				rif.ready <= 1'b0;
				if (rif.valid)
					stall_left--;
			end else begin
				rif.ready <= 1'b1;
			end
		end
	end

	initial begin
		int random_items;
		int counted;
		arst_n       = 1'b0;
		random_items = 0;

		// Empty body: a zero size line ends it at once.
		put("0"); put(CR_CHAR); put(hcbd_pkg::LF_CHAR);
		void'(emit_body(-1, 1'b0));
		// A line with no digits, then a byte after the end that must be ignored.
		put(hcbd_pkg::LF_CHAR); put("A");
		void'(emit_body(-1, 1'b0));
		// Hex after an extension is ignored; junk in the trailer is skipped.
		put("1"); put(";"); put("a"); put(hcbd_pkg::LF_CHAR); put(8'hFF);
		put("x"); put(CR_CHAR); put(hcbd_pkg::LF_CHAR); put("0"); put(hcbd_pkg::LF_CHAR);
		void'(emit_body(-1, 1'b0));
		// Seventh significant digit overflows the size.
		put("1");
		repeat (6) put("0");
		void'(emit_body(-1, 1'b0));
		// Body that ends on a payload byte.
		put("2"); put(hcbd_pkg::LF_CHAR); put(8'h00);
		void'(emit_body(2, 1'b0));

		while (random_items < RANDOM_ITEMS) begin
			build_random_body(counted);
			random_items += counted;
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_bytes.size() != 0 || bif.valid)
			@(posedge clk);
		while (decoded_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (errors == 0 && decoded_q.size() == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
